// ----- sv/mi3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg: shared types for the 3x3 matrix inverse
// Item structs for the input and result channels and the work descriptor
// passed from the front to the back.
// ----------------------------------------------------------------------------
package mi3_pkg;

    typedef struct packed {
        logic signed [15:0] a11;
        logic signed [15:0] a12;
        logic signed [15:0] a13;
        logic signed [15:0] a21;
        logic signed [15:0] a22;
        logic signed [15:0] a23;
        logic signed [15:0] a31;
        logic signed [15:0] a32;
        logic signed [15:0] a33;
    } mi3_in_t;

    typedef struct packed {
        logic signed [31:0] inv11;
        logic signed [31:0] inv12;
        logic signed [31:0] inv13;
        logic signed [31:0] inv21;
        logic signed [31:0] inv22;
        logic signed [31:0] inv23;
        logic signed [31:0] inv31;
        logic signed [31:0] inv32;
        logic signed [31:0] inv33;
        logic               singular;
    } mi3_out_t;

    localparam int unsigned NUM_ENT = 9;
    localparam int unsigned ADJ_W   = 33;
    localparam int unsigned DET_W   = 49;

    // Adjugate entries in row-major result order, plus the determinant.
    typedef struct packed {
        logic signed [NUM_ENT-1:0][ADJ_W-1:0] adj;
        logic signed [DET_W-1:0]              det;
    } mi3_work_t;

endpackage

// ----- sv/mi3_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_front: cofactor and determinant front end
// Two-stage pipeline: products and cofactors, then the determinant.
// ----------------------------------------------------------------------------
module mi3_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mi3_pkg::mi3_in_t   s_data,
    output logic               f_valid,
    input  logic               f_ready,
    output mi3_pkg::mi3_work_t f_data
);
    import mi3_pkg::*;

    logic                  st1_valid_reg;
    logic signed [32:0]    c_reg [NUM_ENT];
    logic signed [15:0]    r1_reg [3];
    logic                  st2_valid_reg;
    mi3_work_t             st2_reg;
    logic                  adv2, adv1;

    function automatic logic signed [32:0] cof(input logic signed [15:0] p,
        input logic signed [15:0] q, input logic signed [15:0] r,
        input logic signed [15:0] s);
        logic signed [32:0] x, y;
        x = 33'(p) * 33'(q);
        y = 33'(r) * 33'(s);
        return x - y;
    endfunction

    assign adv2    = !st2_valid_reg || f_ready;
    assign adv1    = !st1_valid_reg || adv2;
    assign s_ready = adv1;
    assign f_valid = st2_valid_reg;
    assign f_data  = st2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            if (adv1) st1_valid_reg <= s_valid;
            if (adv2) st2_valid_reg <= st1_valid_reg;
        end
        if (adv1 && s_valid) begin
            // Adjugate order: C11 C21 C31 C12 C22 C32 C13 C23 C33.
            c_reg[0] <= cof(s_data.a22, s_data.a33, s_data.a23, s_data.a32);
            c_reg[1] <= cof(s_data.a13, s_data.a32, s_data.a12, s_data.a33);
            c_reg[2] <= cof(s_data.a12, s_data.a23, s_data.a13, s_data.a22);
            c_reg[3] <= cof(s_data.a23, s_data.a31, s_data.a21, s_data.a33);
            c_reg[4] <= cof(s_data.a11, s_data.a33, s_data.a13, s_data.a31);
            c_reg[5] <= cof(s_data.a13, s_data.a21, s_data.a11, s_data.a23);
            c_reg[6] <= cof(s_data.a21, s_data.a32, s_data.a22, s_data.a31);
            c_reg[7] <= cof(s_data.a12, s_data.a31, s_data.a11, s_data.a32);
            c_reg[8] <= cof(s_data.a11, s_data.a22, s_data.a12, s_data.a21);
            r1_reg[0] <= s_data.a11;
            r1_reg[1] <= s_data.a12;
            r1_reg[2] <= s_data.a13;
        end
        if (adv2 && st1_valid_reg) begin
            for (int i = 0; i < NUM_ENT; i++) st2_reg.adj[i] <= c_reg[i];
            st2_reg.det <= DET_W'(r1_reg[0]) * DET_W'(c_reg[0])
                         + DET_W'(r1_reg[1]) * DET_W'(c_reg[3])
                         + DET_W'(r1_reg[2]) * DET_W'(c_reg[6]);
        end
    end
endmodule

// ----- sv/mi3_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_queue: two-entry descriptor queue
// Decouples the front end from the divider back end.
// ----------------------------------------------------------------------------
module mi3_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               w_valid,
    output logic               w_ready,
    input  mi3_pkg::mi3_work_t w_data,
    output logic               r_valid,
    input  logic               r_ready,
    output mi3_pkg::mi3_work_t r_data
);
    import mi3_pkg::*;

    mi3_work_t mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      wr, rd;

    assign w_ready = cnt_reg != 2'd2;
    assign r_valid = cnt_reg != 2'd0;
    assign r_data  = mem_reg[rp_reg];
    assign wr = w_valid && w_ready;
    assign rd = r_valid && r_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
        if (wr) mem_reg[wp_reg] <= w_data;
    end
endmodule

// ----- sv/mi3_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div: pipelined signed divider for one quotient
// Restoring division of |adj|*2^24 by |det|, up to four quotient bits per stage.
// ----------------------------------------------------------------------------
module mi3_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               i_valid,
    input  logic signed [32:0] i_adj,
    input  logic signed [48:0] i_det,
    input  logic               i_last,
    output logic               o_valid,
    output logic signed [31:0] o_q,
    output logic               o_last
);
    import mi3_pkg::*;

    localparam int QW = 57;
    localparam int BPS = 4;
    localparam int NST = (QW + BPS - 1) / BPS;

    // Per stage: remainder, shifting numerator/quotient, divisor, sign.
    logic [NST:0]          v_reg, l_reg, s_reg;
    logic [48:0]           r_reg [NST+1];
    logic [QW-1:0]         n_reg [NST+1];
    logic [47:0]           d_reg [NST+1];
    logic [32:0]           amag;
    logic [48:0]           dmag;
    logic [QW-1:0]         qraw;
    logic                  ovf;

    always_comb begin
        amag = i_adj[32] ? 33'(-i_adj) : i_adj;
        dmag = i_det[48] ? 49'(-i_det) : i_det;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-1:0], i_valid};
        end
        if (en) begin
            l_reg <= {l_reg[NST-1:0], i_last};
            s_reg <= {s_reg[NST-1:0], i_adj[32] ^ i_det[48]};
            r_reg[0] <= '0;
            n_reg[0] <= {1'b0, amag[31:0], 24'd0};
            d_reg[0] <= dmag[47:0];
            for (int s = 0; s < NST; s++) begin
                logic [49:0]   r;
                logic [QW-1:0] n;
                logic          b;
                r = {1'b0, r_reg[s]};
                n = n_reg[s];
                for (int k = 0; k < BPS; k++) begin
                    if (s * BPS + k >= NST * BPS - QW) begin
                        r = {r[48:0], n[QW-1]};
                        n = {n[QW-2:0], 1'b0};
                        b = r >= {2'b0, d_reg[s]};
                        if (b) r = r - {2'b0, d_reg[s]};
                        n[0] = b;
                    end
                end
                r_reg[s+1] <= r[48:0];
                n_reg[s+1] <= n;
                d_reg[s+1] <= d_reg[s];
            end
        end
    end

    // n_reg[0] packs the adj magnitude; bit 32 of amag only arises for -2^32
    // which cannot occur (cofactor range is below 2^32 in magnitude).
    assign qraw = n_reg[NST];
    always_comb begin
        ovf = s_reg[NST] ? (qraw > 57'h80000000) : (qraw > 57'h7FFFFFFF);
        if (ovf) o_q = s_reg[NST] ? 32'sh80000000 : 32'sh7FFFFFFF;
        else     o_q = s_reg[NST] ? -$signed(qraw[31:0]) : $signed(qraw[31:0]);
    end
    assign o_valid = v_reg[NST];
    assign o_last  = l_reg[NST];
endmodule

// ----- sv/mi3_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_back: divider sequencer and result assembly
// Feeds nine adjugate entries through one divider and collects the result.
// ----------------------------------------------------------------------------
module mi3_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  mi3_pkg::mi3_work_t  q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mi3_pkg::mi3_out_t   m_data
);
    import mi3_pkg::*;

    logic [3:0]         idx_reg;
    logic [3:0]         col_reg;
    logic signed [31:0] acc_reg [NUM_ENT];
    logic               sing_reg;
    logic               out_valid_reg;
    mi3_out_t           out_reg;
    logic               en, issue, d_valid, d_last, zero;
    logic signed [31:0] d_q;

    // Pipeline stalls only when a finished result cannot be delivered.
    assign en    = !(d_valid && d_last && out_valid_reg && !m_ready);
    assign issue = en && q_valid;
    assign q_ready = issue && idx_reg == 4'(NUM_ENT - 1);
    assign zero  = q_data.det == '0;

    mi3_div u_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .i_valid(issue),
        .i_adj(zero ? 33'sd0 : q_data.adj[idx_reg]),
        .i_det(zero ? 49'sd1 : q_data.det),
        .i_last(idx_reg == 4'(NUM_ENT - 1)),
        .o_valid(d_valid), .o_q(d_q), .o_last(d_last)
    );

    // Track singular through a tag line as long as the divider pipeline.
    localparam int LAT = 16;
    logic [LAT-1:0] sg_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            sg_reg <= {sg_reg[LAT-2:0], zero};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (issue)
                idx_reg <= (idx_reg == 4'(NUM_ENT - 1)) ? '0 : idx_reg + 4'd1;
            if (en && d_valid && d_last) out_valid_reg <= 1'b1;
            else if (m_ready)            out_valid_reg <= 1'b0;
            if (en && d_valid) begin
                col_reg <= d_last ? '0 : col_reg + 4'd1;
            end
        end
        if (en && d_valid) begin
            acc_reg[col_reg] <= d_q;
            if (d_last) begin
                out_reg <= {acc_reg[0], acc_reg[1], acc_reg[2], acc_reg[3],
                            acc_reg[4], acc_reg[5], acc_reg[6], acc_reg[7],
                            d_q, sg_reg[LAT-1]};
            end
        end
    end
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
endmodule

// ----- sv/matrix_inverse_3x3.sv -----
`timescale 1ns / 1ps
// Throughput: set by the single pipelined divider, which produces one of the
// nine quotients per cycle while work is queued and the result output is not stalled.
// Reset: aresetn is synchronous, active low; it empties all pipelines.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: 3x3 inverse by adjugate and determinant
// Front computes cofactors and determinant, a queue buffers work, back divides.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mi3_pkg::mi3_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mi3_pkg::mi3_out_t  m_data
);
    import mi3_pkg::*;

    mi3_work_t f_data, q_data;
    logic      f_valid, f_ready, q_valid, q_ready;

    // The front end computes all cofactors and the determinant per item.
    mi3_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .f_valid(f_valid), .f_ready(f_ready), .f_data(f_data)
    );

    // The queue lets the front run ahead while the divider is busy.
    mi3_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .w_valid(f_valid), .w_ready(f_ready), .w_data(f_data),
        .r_valid(q_valid), .r_ready(q_ready), .r_data(q_data)
    );

    // The back end issues nine divisions and assembles the result item.
    mi3_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

// ----- verif/tb_matrix_inverse_3x3.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_inverse_3x3: self-checking bench for the 3x3 matrix inverse
// Drives Q8.8 matrices through the valid/ready input and checks every Q16.16
// result and singular flag against an adjugate-based inverse computed in
// 64-bit integers. The bench runs random idle patterns on both sides, a long
// receiver stall, and a drain pause.
// ----------------------------------------------------------------------------
module tb_matrix_inverse_3x3;
    import mi3_pkg::*;

    localparam int unsigned CLK_HALF     = 6;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 300;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    mi3_in_t  s_data;
    logic     m_valid;
    logic     m_ready = 1'b0;
    mi3_out_t m_data;

    // Idle rates in percent, changed between phases by the main sequence.
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    // The main sequence raises this flag; the receiver process counts out the stall.
    logic        hold_req;
    int unsigned hold_left;
    int unsigned n_sent;

    // Keeps the expected inverses in acceptance order and checks results.
    class inverse_scoreboard;
        mi3_out_t    pending_inv[$];
        int unsigned n_mismatch;
        int unsigned n_checked;
        int unsigned n_singular;

        function new();
            n_mismatch = 0;
            n_checked  = 0;
            n_singular = 0;
        endfunction

        // Inverse by the adjugate. Cofactors are exact in Q16.16 and the
        // determinant in Q24.24, so 64-bit integers hold every step exactly.
        function mi3_out_t invert_matrix(mi3_in_t m);
            longint      a [3][3];
            longint      adj [9];
            longint      det;
            longint      q;
            logic [31:0] ent [9];
            mi3_out_t    r;
            a[0][0] = m.a11; a[0][1] = m.a12; a[0][2] = m.a13;
            a[1][0] = m.a21; a[1][1] = m.a22; a[1][2] = m.a23;
            a[2][0] = m.a31; a[2][1] = m.a32; a[2][2] = m.a33;
            // Adjugate is the transposed cofactor matrix, row-major.
            adj[0] = a[1][1] * a[2][2] - a[1][2] * a[2][1];
            adj[3] = a[1][2] * a[2][0] - a[1][0] * a[2][2];
            adj[6] = a[1][0] * a[2][1] - a[1][1] * a[2][0];
            adj[1] = a[0][2] * a[2][1] - a[0][1] * a[2][2];
            adj[4] = a[0][0] * a[2][2] - a[0][2] * a[2][0];
            adj[7] = a[0][1] * a[2][0] - a[0][0] * a[2][1];
            adj[2] = a[0][1] * a[1][2] - a[0][2] * a[1][1];
            adj[5] = a[0][2] * a[1][0] - a[0][0] * a[1][2];
            adj[8] = a[0][0] * a[1][1] - a[0][1] * a[1][0];
            det = a[0][0] * adj[0] + a[0][1] * adj[3] + a[0][2] * adj[6];
            for (int k = 0; k < 9; k++) begin
                if (det == 0) begin
                    ent[k] = '0;
                end else begin
                    // Division on longint truncates toward zero.
                    q = (adj[k] * 64'sd16777216) / det;
                    if (q > 64'sd2147483647) q = 64'sd2147483647;
                    if (q < -64'sd2147483648) q = -64'sd2147483648;
                    ent[k] = q[31:0];
                end
            end
            r.inv11 = ent[0]; r.inv12 = ent[1]; r.inv13 = ent[2];
            r.inv21 = ent[3]; r.inv22 = ent[4]; r.inv23 = ent[5];
            r.inv31 = ent[6]; r.inv32 = ent[7]; r.inv33 = ent[8];
            r.singular = (det == 0);
            return r;
        endfunction

        function void note_matrix(mi3_in_t m);
            mi3_out_t r;
            r = invert_matrix(m);
            if (r.singular) n_singular++;
            pending_inv.push_back(r);
        endfunction

        function void report(string what, longint want, longint got);
            n_mismatch++;
            if (n_mismatch <= 10)
                $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
        endfunction

        function void check_result(mi3_out_t got);
            mi3_out_t    want;
            logic [31:0] w [9];
            logic [31:0] g [9];
            if (pending_inv.size() == 0) begin
                report("unexpected result item", 0, 1);
                return;
            end
            want = pending_inv.pop_front();
            n_checked++;
            w = '{want.inv11, want.inv12, want.inv13, want.inv21, want.inv22,
                  want.inv23, want.inv31, want.inv32, want.inv33};
            g = '{got.inv11, got.inv12, got.inv13, got.inv21, got.inv22,
                  got.inv23, got.inv31, got.inv32, got.inv33};
            for (int k = 0; k < 9; k++) begin
                if (w[k] !== g[k])
                    report($sformatf("inv%0d%0d", k / 3 + 1, k % 3 + 1),
                           $signed(w[k]), $signed(g[k]));
            end
            if (want.singular !== got.singular)
                report("singular", want.singular, got.singular);
        endfunction
    endclass

    inverse_scoreboard inv_sb;

    matrix_inverse_3x3 i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Every accepted input item gets its expected inverse queued at once.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) inv_sb.note_matrix(s_data);
    end

    // Receiver: checks accepted results and decides ready for the next edge.
    // A requested hold is counted here so the sender keeps offering items
    // while the block fills up.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) inv_sb.check_result(m_data);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offers one item, with random idle cycles first, and returns once it is
    // accepted. Valid is left high so back-to-back items follow without a gap.
    task automatic send_matrix(input mi3_in_t m);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= m;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    function automatic mi3_in_t pack_rows(input logic signed [15:0] e [9]);
        mi3_in_t m;
        m.a11 = e[0]; m.a12 = e[1]; m.a13 = e[2];
        m.a21 = e[3]; m.a22 = e[4]; m.a23 = e[5];
        m.a31 = e[6]; m.a32 = e[7]; m.a33 = e[8];
        return m;
    endfunction

    // Mostly invertible matrices of moderate size, with full-range noise,
    // rank-deficient matrices and ones with a tiny diagonal that push the quotients
    // toward saturation.
    function automatic mi3_in_t random_matrix();
        logic signed [15:0] e [9];
        int unsigned        pick;
        int                 span;
        logic               flip;
        pick = $urandom_range(99);
        span = ($urandom_range(1)) ? 1024 : 8192;
        for (int k = 0; k < 9; k++) begin
            if (pick < 35) e[k] = 16'($urandom());
            else e[k] = 16'($signed($urandom_range(2 * span)) - span);
        end
        if (pick >= 70 && pick < 85) begin
            // Third row copies or negates the first, so the determinant is zero.
            flip = 1'($urandom_range(1));
            for (int k = 0; k < 3; k++)
                e[6 + k] = flip ? e[k] : -e[k];
        end else if (pick >= 85) begin
            // Tiny diagonal, large off-diagonal terms.
            for (int k = 0; k < 9; k += 4)
                e[k] = 16'($signed($urandom_range(8)) - 4);
        end
        return pack_rows(e);
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (inv_sb.pending_inv.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) send_matrix(random_matrix());
    endtask

    initial begin
        logic signed [15:0] d [9];
        inv_sb        = new();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        hold_req      = 1'b0;
        n_sent        = 0;
        src_idle_pct  = 30;
        sink_idle_pct = 71;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: identity, zero, extremes, sign of the determinant,
        // singular rows and saturation in both directions.
        d = '{256, 0, 0, 0, 256, 0, 0, 0, 256};                 send_matrix(pack_rows(d));
        d = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                       send_matrix(pack_rows(d));
        d = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_matrix(pack_rows(d));
        d = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_matrix(pack_rows(d));
        d = '{-32768, 0, 0, 0, 32767, 0, 0, 0, -32768};         send_matrix(pack_rows(d));
        d = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};           send_matrix(pack_rows(d));
        d = '{-256, 0, 0, 0, 256, 0, 0, 0, 256};                send_matrix(pack_rows(d));
        d = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                       send_matrix(pack_rows(d));
        d = '{1, 32767, 0, 0, 1, 0, 0, 0, 1};                   send_matrix(pack_rows(d));
        d = '{1, -32768, 0, 0, 1, 0, 0, 0, 1};                  send_matrix(pack_rows(d));
        d = '{-1, 32767, -32768, 0, 1, 32767, 0, 0, -1};        send_matrix(pack_rows(d));
        d = '{512, 256, 768, 1024, 512, 1536, 3, 7, 11};        send_matrix(pack_rows(d));
        d = '{768, 256, 512, 0, 512, 256, 1280, 1536, 0};       send_matrix(pack_rows(d));
        d = '{-1, -1, -1, -1, -2, -3, 1, 4, 9};                 send_matrix(pack_rows(d));
        d = '{21845, -21846, 5461, -5462, 10922, -10923, 1, 2, 3};
        send_matrix(pack_rows(d));

        // Phase one: sender idles 30 percent, receiver 71 percent.
        run_random(200);

        // The sender waits for every result, then a drain pause.
        wait_drained();

        // Phase two: the other way round.
        src_idle_pct  = 71;
        sink_idle_pct = 30;
        run_random(200);

        // Phase three: no idling. A long receiver stall first, while the
        // sender keeps offering items until the input stalls.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        s_valid  <= 1'b0;
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        run_random(200);

        s_valid <= 1'b0;
        wait_drained();

        $display("Checked %0d of %0d matrices, %0d of them singular, under three idle patterns,",
                 inv_sb.n_checked, n_sent, inv_sb.n_singular);
        $display("a %0d-cycle receiver stall and a drain pause; %0d mismatches.",
                 HOLD_CYCLES, inv_sb.n_mismatch);
        if (inv_sb.n_mismatch == 0 && inv_sb.pending_inv.size() == 0) begin
            $display("tb_matrix_inverse_3x3: done, clean");
        end else begin
            $display("tb_matrix_inverse_3x3: done, errors");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of 615 items.
    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding.", inv_sb.pending_inv.size());
        $display("tb_matrix_inverse_3x3: done, errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/mi3_pkg.sv
sv/mi3_front.sv
sv/mi3_queue.sv
sv/mi3_div.sv
sv/mi3_back.sv
sv/matrix_inverse_3x3.sv
verif/tb_matrix_inverse_3x3.sv
